[rtl/acm_pkg.sv]
// shared constants and types for the ascii art cell matcher
`timescale 1ns / 1ps
package acm_pkg;

   localparam int GLYPH_GRID  = 10;
   localparam int GLYPH_COUNT = GLYPH_GRID * GLYPH_GRID;
   localparam int GLYPH_AW    = 7;
   localparam int GLYPH_SW    = 18;
   localparam int CELL_SW     = 13;
   localparam int DIST_W      = 34;
   localparam logic [7:0] CHAR_BASE = 8'd32;

   localparam int DEF_IMG_HEIGHT   = 720;
   localparam int DEF_IMG_WIDTH    = 480;
   localparam int DEF_OUT_ROWS     = 100;
   localparam int DEF_OUT_COLS     = 110;
   localparam int DEF_GLYPH_CELL_H = 25;
   localparam int DEF_GLYPH_CELL_W = 23;

   localparam logic [1:0] REQ_GLYPH = 2'd0;
   localparam logic [1:0] REQ_IMAGE = 2'd1;
   localparam logic [1:0] REQ_FINAL = 2'd2;
   localparam logic [1:0] REQ_QUERY = 2'd3;

   localparam logic RSP_DONE = 1'b0;
   localparam logic RSP_CHAR = 1'b1;

   typedef struct packed {
      logic valid;
      logic glyph;
   } store_ctl_type;

   typedef struct packed {
      logic                valid;
      logic [GLYPH_AW-1:0] idx;
   } match_ctl_type;

endpackage

[rtl/acm_sum_store.sv]
// glyph and cell sum memories with read-modify-write load path and clearing pass
`timescale 1ns / 1ps
module acm_sum_store #(
   parameter int CELL_COUNT = acm_pkg::DEF_OUT_ROWS * acm_pkg::DEF_OUT_COLS,
   parameter int CELL_AW    = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  acm_pkg::store_ctl_type       ld_ctl,
   input  logic [CELL_AW-1:0]           ld_addr,
   input  logic [7:0]                   ld_value,
   input  logic [CELL_AW-1:0]           cell_raddr,
   input  logic [acm_pkg::GLYPH_AW-1:0] glyph_raddr,
   output logic [acm_pkg::CELL_SW-1:0]  cell_rdata,
   output logic [acm_pkg::GLYPH_SW-1:0] glyph_rdata,
   output logic                         clearing
);

   localparam int CLR_COUNT = (CELL_COUNT > acm_pkg::GLYPH_COUNT) ?
                              CELL_COUNT : acm_pkg::GLYPH_COUNT;
   localparam int CLR_W     = $clog2(CLR_COUNT + 1);

   logic [acm_pkg::CELL_SW-1:0]  cell_mem [CELL_COUNT];
   logic [acm_pkg::GLYPH_SW-1:0] glyph_mem [acm_pkg::GLYPH_COUNT];

   logic [CLR_W-1:0] clr_ff, clr_in;
   logic             clr_busy_ff, clr_busy_in;

   logic                         s1_valid_ff, s1_glyph_ff, s1_fwd_ff;
   logic [CELL_AW-1:0]           s1_addr_ff;
   logic [7:0]                   s1_value_ff;
   logic [acm_pkg::GLYPH_SW-1:0] last_sum_ff, last_sum_in;
   logic [acm_pkg::CELL_SW-1:0]  cell_rdata_ff, cell_base, cell_sum, cell_wdata;
   logic [acm_pkg::GLYPH_SW-1:0] glyph_rdata_ff, glyph_base, glyph_sum, glyph_wdata;
   logic                         cell_we, glyph_we;
   logic [CELL_AW-1:0]           cell_waddr;
   logic [acm_pkg::GLYPH_AW-1:0] glyph_waddr;

   assign clearing    = clr_busy_ff;
   assign cell_rdata  = cell_rdata_ff;
   assign glyph_rdata = glyph_rdata_ff;

   always_comb begin
      clr_in      = clr_ff + 1'b1;
      clr_busy_in = clr_busy_ff && (clr_ff != CLR_W'(CLR_COUNT - 1));
   end

   // the entry written last cycle was read stale, so take the written value
   always_comb begin
      cell_base   = s1_fwd_ff ? last_sum_ff[acm_pkg::CELL_SW-1:0] : cell_rdata_ff;
      glyph_base  = s1_fwd_ff ? last_sum_ff : glyph_rdata_ff;
      cell_sum    = cell_base + acm_pkg::CELL_SW'(s1_value_ff);
      glyph_sum   = glyph_base + acm_pkg::GLYPH_SW'(s1_value_ff);
      last_sum_in = s1_glyph_ff ? glyph_sum : acm_pkg::GLYPH_SW'(cell_sum);
      if (clr_busy_ff) begin
         cell_we     = (32'(clr_ff) < CELL_COUNT);
         glyph_we    = (32'(clr_ff) < acm_pkg::GLYPH_COUNT);
         cell_waddr  = CELL_AW'(clr_ff);
         glyph_waddr = acm_pkg::GLYPH_AW'(clr_ff);
         cell_wdata  = '0;
         glyph_wdata = '0;
      end else begin
         cell_we     = s1_valid_ff && !s1_glyph_ff;
         glyph_we    = s1_valid_ff && s1_glyph_ff;
         cell_waddr  = s1_addr_ff;
         glyph_waddr = acm_pkg::GLYPH_AW'(s1_addr_ff);
         cell_wdata  = cell_sum;
         glyph_wdata = glyph_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clr_busy_ff <= 1'b1;
         s1_valid_ff <= 1'b0;
      end else begin
         if (clr_busy_ff) begin
            clr_ff      <= clr_in;
            clr_busy_ff <= clr_busy_in;
         end
         s1_valid_ff <= ld_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_ctl.valid) begin
         s1_glyph_ff <= ld_ctl.glyph;
         s1_addr_ff  <= ld_addr;
         s1_value_ff <= ld_value;
         s1_fwd_ff   <= s1_valid_ff && (s1_glyph_ff == ld_ctl.glyph) &&
                        (s1_addr_ff == ld_addr);
      end
      last_sum_ff <= last_sum_in;
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      cell_rdata_ff <= cell_mem[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (glyph_we) begin
         glyph_mem[glyph_waddr] <= glyph_wdata;
      end
      glyph_rdata_ff <= glyph_mem[glyph_raddr];
   end

endmodule

[rtl/acm_glyph_match.sv]
// pipelined cross-multiplied distance and running best glyph search
`timescale 1ns / 1ps
module acm_glyph_match (
   input  logic                         clock,
   input  logic                         reset,
   input  acm_pkg::match_ctl_type       in_ctl,
   input  logic [acm_pkg::GLYPH_SW-1:0] glyph_sum,
   input  logic [acm_pkg::GLYPH_SW-1:0] glyph_low,
   input  logic                         glyph_flat,
   input  logic signed [acm_pkg::CELL_SW:0] cell_diff,
   input  logic [acm_pkg::CELL_SW-1:0]  cell_range,
   input  logic [acm_pkg::GLYPH_SW-1:0] glyph_range,
   output logic [acm_pkg::GLYPH_AW-1:0] best_idx,
   output logic                         done
);

   localparam int PW = acm_pkg::DIST_W - 1;

   logic                         a_valid_ff, b_valid_ff, done_ff;
   logic [acm_pkg::GLYPH_AW-1:0] a_idx_ff, b_idx_ff, best_idx_ff;
   logic signed [PW-1:0]         p1_ff, p2_ff, p1_in, p2_in;
   logic signed [PW-1:0]         a_ext, gr_ext, g_ext, cr_ext;
   logic signed [acm_pkg::GLYPH_SW:0] g_diff;
   logic signed [acm_pkg::DIST_W-1:0] diff;
   logic [acm_pkg::DIST_W-1:0]   d_ff, d_in, best_ff;

   always_comb begin
      g_diff = glyph_flat ? '0 :
               $signed({1'b0, glyph_sum}) - $signed({1'b0, glyph_low});
      a_ext  = PW'(cell_diff);
      gr_ext = PW'($signed({1'b0, glyph_range}));
      g_ext  = PW'(g_diff);
      cr_ext = PW'($signed({1'b0, cell_range}));
      p1_in  = a_ext * gr_ext;
      p2_in  = g_ext * cr_ext;
      diff   = acm_pkg::DIST_W'(p1_ff) - acm_pkg::DIST_W'(p2_ff);
      d_in   = diff[acm_pkg::DIST_W-1] ? acm_pkg::DIST_W'(-diff) : acm_pkg::DIST_W'(diff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         a_valid_ff <= in_ctl.valid;
         b_valid_ff <= a_valid_ff;
         done_ff    <= b_valid_ff && (b_idx_ff == acm_pkg::GLYPH_AW'(acm_pkg::GLYPH_COUNT - 1));
      end
   end

   always_ff @(posedge clock) begin
      a_idx_ff <= in_ctl.idx;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      b_idx_ff <= a_idx_ff;
      d_ff     <= d_in;
      // first glyph seeds the search, ties keep the earlier index
      if (b_valid_ff && ((b_idx_ff == '0) || (d_ff < best_ff))) begin
         best_ff     <= d_ff;
         best_idx_ff <= b_idx_ff;
      end
   end

   assign best_idx = best_idx_ff;
   assign done     = done_ff;

endmodule

[rtl/ascii_art_cell_matcher_core.sv]
// top level: request decode, finalize and query sequencing, result register
`timescale 1ns / 1ps
// pixel loads: one transaction per cycle while idle, read-modify-write with forwarding
// finalize: walks max(cells, 100) entries, one entry read per cycle, then emits the result
// query: one glyph per cycle through a 3-stage distance pipe
// requests wait while a walk runs or a stalled result still holds the output register
// reset: synchronous; a clearing pass over max(cells, 100) entries zeroes both memories,
// no request is taken until it ends
module ascii_art_cell_matcher_core #(
   parameter int IMG_HEIGHT   = acm_pkg::DEF_IMG_HEIGHT,
   parameter int IMG_WIDTH    = acm_pkg::DEF_IMG_WIDTH,
   parameter int OUT_ROWS     = acm_pkg::DEF_OUT_ROWS,
   parameter int OUT_COLS     = acm_pkg::DEF_OUT_COLS,
   parameter int GLYPH_CELL_H = acm_pkg::DEF_GLYPH_CELL_H,
   parameter int GLYPH_CELL_W = acm_pkg::DEF_GLYPH_CELL_W
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pixel_value, pixel_row, pixel_col, cell_row, cell_col, zero fill
   input  logic [47:0] req_tdata,
   // req_type
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // char_code
   output logic [7:0]  rsp_tdata,
   // result_kind
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   localparam int CELL_COUNT = OUT_ROWS * OUT_COLS;
   localparam int CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int CELL_H     = IMG_HEIGHT / OUT_ROWS;
   localparam int CELL_W     = IMG_WIDTH / OUT_COLS;
   localparam int CELL_H_DIV = (CELL_H == 0) ? 1 : CELL_H;
   localparam int CELL_W_DIV = (CELL_W == 0) ? 1 : CELL_W;
   localparam int WALK       = (CELL_COUNT > acm_pkg::GLYPH_COUNT) ?
                               CELL_COUNT : acm_pkg::GLYPH_COUNT;
   localparam int WALK_W     = $clog2(WALK + 1);
   localparam int GAW        = acm_pkg::GLYPH_AW;
   localparam int CSW        = acm_pkg::CELL_SW;
   localparam int GSW        = acm_pkg::GLYPH_SW;

   // reciprocal multipliers, exact for every 10-bit row and 9-bit column
   localparam int GH_S = 10 + $clog2(GLYPH_CELL_H);
   localparam int GH_M = ((1 << GH_S) + GLYPH_CELL_H - 1) / GLYPH_CELL_H;
   localparam int GW_S = 9 + $clog2(GLYPH_CELL_W);
   localparam int GW_M = ((1 << GW_S) + GLYPH_CELL_W - 1) / GLYPH_CELL_W;
   localparam int CH_S = 10 + $clog2(CELL_H_DIV);
   localparam int CH_M = ((1 << CH_S) + CELL_H_DIV - 1) / CELL_H_DIV;
   localparam int CW_S = 9 + $clog2(CELL_W_DIV);
   localparam int CW_M = ((1 << CW_S) + CELL_W_DIV - 1) / CELL_W_DIV;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FIN   = 3'd1;
   localparam logic [2:0] S_FTAIL = 3'd2;
   localparam logic [2:0] S_QRD   = 3'd3;
   localparam logic [2:0] S_QRUN  = 3'd4;
   localparam logic [2:0] S_QWAIT = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;
   localparam logic [2:0] S_QPRE  = 3'd7;

   logic [7:0] pixel_value;
   logic [9:0] pixel_row;
   logic [8:0] pixel_col;
   logic [6:0] cell_row, cell_col;

   assign pixel_value = req_tdata[7:0];
   assign pixel_row   = req_tdata[17:8];
   assign pixel_col   = req_tdata[26:18];
   assign cell_row    = req_tdata[33:27];
   assign cell_col    = req_tdata[40:34];

   logic [2:0] state_ff, state_in;
   logic       accept, clearing;
   logic [9:0] g_row, c_row;
   logic [8:0] g_col, c_col;
   logic       g_hit, c_hit, q_hit;
   logic [GAW-1:0]     g_idx;
   logic [CELL_AW-1:0] c_idx, q_idx, ld_addr, cell_raddr;
   logic [CELL_AW-1:0] q_addr_ff;
   logic [GAW-1:0]     glyph_raddr;
   acm_pkg::store_ctl_type ld_ctl;
   acm_pkg::match_ctl_type m_ctl;
   logic [CSW-1:0] cell_rdata;
   logic [GSW-1:0] glyph_rdata;

   logic [WALK_W-1:0] w_ff, w_in, fi_ff;
   logic              fv_ff;
   logic [GAW-1:0]    j_ff, j_in;
   logic              mv_ff;
   logic [GAW-1:0]    mi_ff;
   logic [CSW-1:0]    cell_low_ff, cell_high_ff;
   logic [GSW-1:0]    glyph_low_ff, glyph_high_ff;
   logic signed [CSW:0] a_ff, a_in;
   logic [CSW-1:0]    crange_ff, crange_in;
   logic [GSW-1:0]    grange_ff, grange_in;
   logic              gflat_ff;
   logic              q_end_ff;
   logic [GAW-1:0]    best_idx;
   logic              match_done;
   logic              pend_kind_ff, pend_end_ff;
   logic [7:0]        pend_char_ff;
   logic              rsp_valid_ff, rsp_kind_ff, rsp_end_ff;
   logic [7:0]        rsp_char_ff;
   logic              emit_go;

   assign req_tready = (state_ff == S_IDLE) && !clearing;
   assign accept     = req_tvalid && req_tready;

   // pixel to glyph cell and image cell
   always_comb begin
      g_row = 10'((32'(pixel_row) * 32'(GH_M)) >> GH_S);
      g_col = 9'((32'(pixel_col) * 32'(GW_M)) >> GW_S);
      c_row = 10'((32'(pixel_row) * 32'(CH_M)) >> CH_S);
      c_col = 9'((32'(pixel_col) * 32'(CW_M)) >> CW_S);
      g_hit = (32'(g_row) < acm_pkg::GLYPH_GRID) && (32'(g_col) < acm_pkg::GLYPH_GRID);
      c_hit = (CELL_H != 0) && (CELL_W != 0) &&
              (32'(c_row) < OUT_ROWS) && (32'(c_col) < OUT_COLS);
      q_hit = (32'(cell_row) < OUT_ROWS) && (32'(cell_col) < OUT_COLS);
      g_idx = GAW'(32'(g_row) * acm_pkg::GLYPH_GRID + 32'(g_col));
      c_idx = CELL_AW'(32'(c_row) * OUT_COLS + 32'(c_col));
      q_idx = CELL_AW'(32'(cell_row) * OUT_COLS + 32'(cell_col));
      ld_ctl.glyph = (req_tuser == acm_pkg::REQ_GLYPH);
      ld_ctl.valid = accept && ((ld_ctl.glyph && g_hit) ||
                                ((req_tuser == acm_pkg::REQ_IMAGE) && c_hit));
      ld_addr      = ld_ctl.glyph ? CELL_AW'(g_idx) : c_idx;
   end

   always_comb begin
      case (state_ff)
         S_FIN: begin
            cell_raddr  = CELL_AW'(w_ff);
            glyph_raddr = GAW'(w_ff);
         end
         // read the queried cell once the last load has been written
         S_QPRE: begin
            cell_raddr  = q_addr_ff;
            glyph_raddr = '0;
         end
         S_QRD: begin
            cell_raddr  = ld_addr;
            glyph_raddr = '0;
         end
         S_QRUN: begin
            cell_raddr  = ld_addr;
            glyph_raddr = j_ff;
         end
         default: begin
            cell_raddr  = (req_tuser == acm_pkg::REQ_QUERY) ? q_idx : ld_addr;
            glyph_raddr = GAW'(ld_addr);
         end
      endcase
   end

   acm_sum_store #(
      .CELL_COUNT (CELL_COUNT),
      .CELL_AW    (CELL_AW)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .ld_ctl      (ld_ctl),
      .ld_addr     (ld_addr),
      .ld_value    (pixel_value),
      .cell_raddr  (cell_raddr),
      .glyph_raddr (glyph_raddr),
      .cell_rdata  (cell_rdata),
      .glyph_rdata (glyph_rdata),
      .clearing    (clearing)
   );

   // query operands from the freshly read cell sum
   always_comb begin
      if (cell_high_ff == cell_low_ff) begin
         a_in      = '0;
         crange_in = CSW'(1);
      end else begin
         a_in      = $signed({1'b0, cell_rdata}) - $signed({1'b0, cell_low_ff});
         crange_in = cell_high_ff - cell_low_ff;
      end
      grange_in = (glyph_high_ff == glyph_low_ff) ? GSW'(1) : glyph_high_ff - glyph_low_ff;
   end

   assign m_ctl.valid = mv_ff;
   assign m_ctl.idx   = mi_ff;

   acm_glyph_match u_match (
      .clock       (clock),
      .reset       (reset),
      .in_ctl      (m_ctl),
      .glyph_sum   (glyph_rdata),
      .glyph_low   (glyph_low_ff),
      .glyph_flat  (gflat_ff),
      .cell_diff   (a_ff),
      .cell_range  (crange_ff),
      .glyph_range (grange_ff),
      .best_idx    (best_idx),
      .done        (match_done)
   );

   assign emit_go = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      w_in     = w_ff + 1'b1;
      j_in     = j_ff + 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_tuser == acm_pkg::REQ_FINAL)) begin
               state_in = S_FIN;
            end else if (accept && (req_tuser == acm_pkg::REQ_QUERY) && q_hit) begin
               state_in = S_QPRE;
            end
            w_in = '0;
         end
         S_FIN: begin
            if (w_ff == WALK_W'(WALK - 1)) begin
               state_in = S_FTAIL;
            end
         end
         S_FTAIL: state_in = S_EMIT;
         S_QPRE: state_in = S_QRD;
         S_QRD: begin
            state_in = S_QRUN;
            j_in     = GAW'(1);
         end
         S_QRUN: begin
            if (j_ff == GAW'(acm_pkg::GLYPH_COUNT - 1)) begin
               state_in = S_QWAIT;
            end
         end
         S_QWAIT: begin
            if (match_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit_go) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fv_ff         <= 1'b0;
         mv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cell_low_ff   <= '0;
         cell_high_ff  <= '0;
         glyph_low_ff  <= '0;
         glyph_high_ff <= '0;
      end else begin
         state_ff <= state_in;
         fv_ff    <= (state_ff == S_FIN);
         mv_ff    <= (state_ff == S_QRD) || (state_ff == S_QRUN);
         if (fv_ff) begin
            if (fi_ff == '0) begin
               cell_low_ff   <= cell_rdata;
               cell_high_ff  <= cell_rdata;
               glyph_low_ff  <= glyph_rdata;
               glyph_high_ff <= glyph_rdata;
            end else begin
               if (32'(fi_ff) < CELL_COUNT) begin
                  if (cell_rdata < cell_low_ff)  cell_low_ff  <= cell_rdata;
                  if (cell_rdata > cell_high_ff) cell_high_ff <= cell_rdata;
               end
               if (32'(fi_ff) < acm_pkg::GLYPH_COUNT) begin
                  if (glyph_rdata < glyph_low_ff)  glyph_low_ff  <= glyph_rdata;
                  if (glyph_rdata > glyph_high_ff) glyph_high_ff <= glyph_rdata;
               end
            end
         end
         if ((state_ff == S_EMIT) && emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff  <= w_in;
      j_ff  <= j_in;
      fi_ff <= w_ff;
      mi_ff <= glyph_raddr;
      if (accept) begin
         q_end_ff  <= (32'(cell_col) == OUT_COLS - 1);
         q_addr_ff <= q_idx;
      end
      if (state_ff == S_QRD) begin
         a_ff      <= a_in;
         crange_ff <= crange_in;
         grange_ff <= grange_in;
         gflat_ff  <= (glyph_high_ff == glyph_low_ff);
      end
      if (state_ff == S_FTAIL) begin
         pend_kind_ff <= acm_pkg::RSP_DONE;
         pend_char_ff <= '0;
         pend_end_ff  <= 1'b0;
      end else if ((state_ff == S_QWAIT) && match_done) begin
         pend_kind_ff <= acm_pkg::RSP_CHAR;
         pend_char_ff <= acm_pkg::CHAR_BASE + 8'(best_idx);
         pend_end_ff  <= q_end_ff;
      end
      if ((state_ff == S_EMIT) && emit_go) begin
         rsp_kind_ff <= pend_kind_ff;
         rsp_char_ff <= pend_char_ff;
         rsp_end_ff  <= pend_end_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_end_ff;

`ifndef SYNTH
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_tready)
      else $error("request taken during clearing pass");

   a_done_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == acm_pkg::RSP_DONE)) |-> (rsp_tdata == 8'd0 && !rsp_tlast))
      else $error("finalize result carries a payload");

   a_query_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_QRUN) |=> (state_ff == S_QRUN || state_ff == S_QWAIT))
      else $error("glyph walk left early");
`endif

endmodule
